>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define RTC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtc checker: same-cycle property failed");

// Implication checked in the cycle after the antecedent.
`define RTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtc checker: next-cycle property failed");

`endif

>>> rtl/core/rtc_pkg.sv
// Shared types, constants and helper functions for the ray/triangle core.
// Used by the controller, datapath, divider and top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtc_pkg;

    // Number formats.
    localparam int FRAC_BITS = 16;
    localparam int Q_W       = 32;
    localparam int DIR_W     = 18;
    localparam int DIST_W    = 31;
    localparam int ACC_W     = 2 * Q_W - FRAC_BITS + 2;
    localparam int DVD_W     = 2 * FRAC_BITS + 1;
    localparam int CNT_W     = $clog2(DVD_W + 1);
    localparam int PC_W      = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [Q_W-1:0] ONE_P1   = Q_W'((64'd1 << FRAC_BITS) + 64'd1);
    localparam logic signed [Q_W-1:0] MINUS1   = -Q_W'(1);
    localparam logic signed [Q_W-1:0] Q_MAX    = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN    = {1'b1, {(Q_W-1){1'b0}}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 3'd6;

    // Operand source codes for the shared multiply-accumulate unit.
    localparam logic [4:0] SRC_D0 = 5'd0,  SRC_D1 = 5'd1,  SRC_D2 = 5'd2;
    localparam logic [4:0] SRC_E10 = 5'd3, SRC_E11 = 5'd4, SRC_E12 = 5'd5;
    localparam logic [4:0] SRC_E20 = 5'd6, SRC_E21 = 5'd7, SRC_E22 = 5'd8;
    localparam logic [4:0] SRC_S0 = 5'd9,  SRC_S1 = 5'd10, SRC_S2 = 5'd11;
    localparam logic [4:0] SRC_P0 = 5'd12, SRC_P1 = 5'd13, SRC_P2 = 5'd14;
    localparam logic [4:0] SRC_Q0 = 5'd15, SRC_Q1 = 5'd16, SRC_Q2 = 5'd17;
    localparam logic [4:0] SRC_RECIP = 5'd18, SRC_TU = 5'd19, SRC_TV = 5'd20;
    localparam logic [4:0] SRC_TT = 5'd21, SRC_T = 5'd22;

    // Destination codes for the accumulator result.
    localparam logic [4:0] DST_NONE = 5'd0;
    localparam logic [4:0] DST_P0 = 5'd1, DST_P1 = 5'd2, DST_P2 = 5'd3;
    localparam logic [4:0] DST_DET = 5'd4, DST_TU = 5'd5;
    localparam logic [4:0] DST_Q0 = 5'd6, DST_Q1 = 5'd7, DST_Q2 = 5'd8;
    localparam logic [4:0] DST_TV = 5'd9, DST_TT = 5'd10;
    localparam logic [4:0] DST_U = 5'd11, DST_V = 5'd12, DST_T = 5'd13;
    localparam logic [4:0] DST_BP0 = 5'd14, DST_BP1 = 5'd15, DST_BP2 = 5'd16;

    // Program counter landmarks.
    localparam logic [PC_W-1:0] PC_DIV_START = 5'd9;
    localparam logic [PC_W-1:0] PC_T_DONE    = 5'd26;
    localparam logic [PC_W-1:0] PC_POINT     = 5'd27;
    localparam logic [PC_W-1:0] PC_END       = 5'd29;

    // One step of the datapath program.
    typedef struct packed {
        logic [4:0] a_sel;
        logic [4:0] b_sel;
        logic       neg;
        logic       first;
        logic       org;
        logic       last;
        logic       wait_div;
        logic [4:0] dest;
    } op_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic mesh_start;
        logic exec;
        op_t  op;
        logic div_start;
        logic commit;
        logic load_out;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic det_zero;
        logic div_busy;
        logic hit_ok;
    } status_t;

    function automatic op_t mk_op(input logic [4:0] a, input logic [4:0] b,
                                  input logic neg, input logic first,
                                  input logic org, input logic wait_div,
                                  input logic [4:0] dest);
        op_t o;
        o.a_sel    = a;
        o.b_sel    = b;
        o.neg      = neg;
        o.first    = first;
        o.org      = org;
        o.last     = (dest != DST_NONE);
        o.wait_div = wait_div;
        o.dest     = dest;
        return o;
    endfunction

    // Step sequence: P = d x e2, det, S.P, Q = s x e1, d.Q, e2.Q,
    // then the three scalings by the reciprocal and the hit point.
    function automatic op_t get_op(input logic [PC_W-1:0] pc);
        op_t o;
        o = mk_op(SRC_D0, SRC_D0, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
        case (pc)
            5'd0:  o = mk_op(SRC_D1, SRC_E22, 1'b0, 1'b1, 1'b0, 1'b0, DST_NONE);
            5'd1:  o = mk_op(SRC_D2, SRC_E21, 1'b1, 1'b0, 1'b0, 1'b0, DST_P0);
            5'd2:  o = mk_op(SRC_D2, SRC_E20, 1'b0, 1'b1, 1'b0, 1'b0, DST_NONE);
            5'd3:  o = mk_op(SRC_D0, SRC_E22, 1'b1, 1'b0, 1'b0, 1'b0, DST_P1);
            5'd4:  o = mk_op(SRC_D0, SRC_E21, 1'b0, 1'b1, 1'b0, 1'b0, DST_NONE);
            5'd5:  o = mk_op(SRC_D1, SRC_E20, 1'b1, 1'b0, 1'b0, 1'b0, DST_P2);
            5'd6:  o = mk_op(SRC_E10, SRC_P0, 1'b0, 1'b1, 1'b0, 1'b0, DST_NONE);
            5'd7:  o = mk_op(SRC_E11, SRC_P1, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
            5'd8:  o = mk_op(SRC_E12, SRC_P2, 1'b0, 1'b0, 1'b0, 1'b0, DST_DET);
            5'd9:  o = mk_op(SRC_S0, SRC_P0, 1'b0, 1'b1, 1'b0, 1'b0, DST_NONE);
            5'd10: o = mk_op(SRC_S1, SRC_P1, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
            5'd11: o = mk_op(SRC_S2, SRC_P2, 1'b0, 1'b0, 1'b0, 1'b0, DST_TU);
            5'd12: o = mk_op(SRC_S1, SRC_E12, 1'b0, 1'b1, 1'b0, 1'b0, DST_NONE);
            5'd13: o = mk_op(SRC_S2, SRC_E11, 1'b1, 1'b0, 1'b0, 1'b0, DST_Q0);
            5'd14: o = mk_op(SRC_S2, SRC_E10, 1'b0, 1'b1, 1'b0, 1'b0, DST_NONE);
            5'd15: o = mk_op(SRC_S0, SRC_E12, 1'b1, 1'b0, 1'b0, 1'b0, DST_Q1);
            5'd16: o = mk_op(SRC_S0, SRC_E11, 1'b0, 1'b1, 1'b0, 1'b0, DST_NONE);
            5'd17: o = mk_op(SRC_S1, SRC_E10, 1'b1, 1'b0, 1'b0, 1'b0, DST_Q2);
            5'd18: o = mk_op(SRC_D0, SRC_Q0, 1'b0, 1'b1, 1'b0, 1'b0, DST_NONE);
            5'd19: o = mk_op(SRC_D1, SRC_Q1, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
            5'd20: o = mk_op(SRC_D2, SRC_Q2, 1'b0, 1'b0, 1'b0, 1'b0, DST_TV);
            5'd21: o = mk_op(SRC_E20, SRC_Q0, 1'b0, 1'b1, 1'b0, 1'b0, DST_NONE);
            5'd22: o = mk_op(SRC_E21, SRC_Q1, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
            5'd23: o = mk_op(SRC_E22, SRC_Q2, 1'b0, 1'b0, 1'b0, 1'b0, DST_TT);
            5'd24: o = mk_op(SRC_RECIP, SRC_TU, 1'b0, 1'b1, 1'b0, 1'b1, DST_U);
            5'd25: o = mk_op(SRC_RECIP, SRC_TV, 1'b0, 1'b1, 1'b0, 1'b0, DST_V);
            5'd26: o = mk_op(SRC_RECIP, SRC_TT, 1'b0, 1'b1, 1'b0, 1'b0, DST_T);
            5'd27: o = mk_op(SRC_D0, SRC_T, 1'b0, 1'b1, 1'b1, 1'b0, DST_BP0);
            5'd28: o = mk_op(SRC_D1, SRC_T, 1'b0, 1'b1, 1'b1, 1'b0, DST_BP1);
            5'd29: o = mk_op(SRC_D2, SRC_T, 1'b0, 1'b1, 1'b1, 1'b0, DST_BP2);
            default: o = mk_op(SRC_D0, SRC_D0, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
        endcase
        return o;
    endfunction

    // Saturate the accumulator to a Q value.
    function automatic logic signed [Q_W-1:0] sat_acc(input logic signed [ACC_W-1:0] x);
        logic [ACC_W-Q_W:0] hi;
        hi = x[ACC_W-1:Q_W-1];
        if ((&hi) || !(|hi))
            return x[Q_W-1:0];
        return x[ACC_W-1] ? Q_MIN : Q_MAX;
    endfunction

    // Saturate a one-bit-grown difference to a Q value.
    function automatic logic signed [Q_W-1:0] sat_diff(input logic signed [Q_W:0] x);
        if (x[Q_W] == x[Q_W-1])
            return x[Q_W-1:0];
        return x[Q_W] ? Q_MIN : Q_MAX;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rtc_div.sv
// Restoring divider that forms 2^(2*FRAC_BITS) / det, one quotient bit a cycle.
// Depends on rtc_pkg for widths and saturation limits.
`timescale 1ns / 1ps
`default_nettype none

module rtc_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [rtc_pkg::Q_W-1:0] divisor,
    output logic                               busy,
    output logic signed [rtc_pkg::Q_W-1:0]     quot
);

    logic [rtc_pkg::Q_W:0]       rem_reg, rem_next;
    logic [rtc_pkg::DVD_W-1:0]   quo_reg, quo_next;
    logic [rtc_pkg::Q_W-1:0]     dvs_reg, dvs_next;
    logic [rtc_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        neg_reg, neg_next;
    logic [rtc_pkg::Q_W+1:0]     trial;
    logic                        dvd_bit;
    logic                        ge;

    // The dividend has only its top bit set.
    assign dvd_bit = (cnt_reg == rtc_pkg::CNT_W'(rtc_pkg::DVD_W));
    assign trial   = {rem_reg, dvd_bit};
    assign ge      = (trial >= {2'b00, dvs_reg});
    assign busy    = (cnt_reg != '0);

    // Step logic.
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        if (start)
        begin
            rem_next = '0;
            quo_next = '0;
            neg_next = divisor[rtc_pkg::Q_W-1];
            dvs_next = divisor[rtc_pkg::Q_W-1] ? (~divisor + 1'b1) : divisor;
            cnt_next = rtc_pkg::CNT_W'(rtc_pkg::DVD_W);
        end
        else if (busy)
        begin
            rem_next = ge ? (rtc_pkg::Q_W+1)'(trial - {2'b00, dvs_reg})
                          : trial[rtc_pkg::Q_W:0];
            quo_next = {quo_reg[rtc_pkg::DVD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // Apply the sign and saturate to a Q value.
    always_comb
    begin
        if (!neg_reg)
        begin
            if (quo_reg > rtc_pkg::DVD_W'(rtc_pkg::Q_MAX))
                quot = rtc_pkg::Q_MAX;
            else
                quot = quo_reg[rtc_pkg::Q_W-1:0];
        end
        else
        begin
            if (quo_reg > {1'b0, rtc_pkg::Q_MIN})
                quot = rtc_pkg::Q_MIN;
            else
                quot = ~quo_reg[rtc_pkg::Q_W-1:0] + 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rtc_datapath.sv
// Datapath: ray registers, edge vectors, one shared multiply-accumulate unit,
// the reciprocal divider, closest-hit state and the result registers.
// Depends on rtc_pkg and rtc_div.
`timescale 1ns / 1ps
`default_nettype none

module rtc_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire rtc_pkg::cmd_t                         cmd,
    output rtc_pkg::status_t                           status,
    input  wire logic                                  cfg_we,
    input  wire logic [rtc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [rtc_pkg::Q_W-1:0]               cfg_data,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        a_x,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        a_y,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        a_z,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        b_x,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        b_y,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        b_z,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        c_x,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        c_y,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        c_z,
    output logic                                       hit_found,
    output logic [rtc_pkg::DIST_W-1:0]                 hit_dist,
    output logic signed [rtc_pkg::Q_W-1:0]             hit_x,
    output logic signed [rtc_pkg::Q_W-1:0]             hit_y,
    output logic signed [rtc_pkg::Q_W-1:0]             hit_z
);

    localparam int QW = rtc_pkg::Q_W;
    localparam int AW = rtc_pkg::ACC_W;
    localparam int DW = rtc_pkg::DIR_W;

    // Ray configuration.
    logic signed [QW-1:0] org_reg [3];
    logic signed [DW-1:0] dir_reg [3];
    logic [rtc_pkg::DIST_W-1:0] max_reg;

    // Per-triangle operands.
    logic signed [QW-1:0] e1_reg [3];
    logic signed [QW-1:0] e2_reg [3];
    logic signed [QW-1:0] s_reg [3];
    logic signed [QW-1:0] p_reg [3];
    logic signed [QW-1:0] q_reg [3];
    logic signed [QW-1:0] det_reg, tu_reg, tv_reg, tt_reg, u_reg, v_reg, t_reg;
    logic signed [AW-1:0] acc_reg;

    // Closest-hit state.
    logic                 best_found_reg;
    logic signed [QW-1:0] best_dist_reg;
    logic signed [QW-1:0] best_pt_reg [3];

    // Result registers.
    logic                       out_found_reg;
    logic [rtc_pkg::DIST_W-1:0] out_dist_reg;
    logic signed [QW-1:0]       out_pt_reg [3];

    logic signed [QW-1:0]   recip;
    logic                   div_busy;
    logic signed [QW-1:0]   op_a, op_b;
    logic signed [2*QW-1:0] prod;
    logic signed [2*QW-1:0] prod_sh;
    logic signed [AW-1:0]   base;
    logic signed [AW-1:0]   acc_next;
    logic signed [QW-1:0]   acc_sat;
    logic signed [QW-1:0]   base_org;
    logic signed [QW:0]     uv_sum;
    logic signed [QW-1:0]   max_s;
    logic signed [QW-1:0]   vert_a [3];
    logic signed [QW-1:0]   vert_b [3];
    logic signed [QW-1:0]   vert_c [3];

    assign vert_a = '{a_x, a_y, a_z};
    assign vert_b = '{b_x, b_y, b_z};
    assign vert_c = '{c_x, c_y, c_z};

    rtc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .divisor (det_reg),
        .busy    (div_busy),
        .quot    (recip)
    );

    // Operand selection for the shared multiplier.
    function automatic logic signed [QW-1:0] pick(input logic [4:0] sel,
            input logic signed [QW-1:0] d0, input logic signed [QW-1:0] d1,
            input logic signed [QW-1:0] d2,
            input logic signed [QW-1:0] e1 [3], input logic signed [QW-1:0] e2 [3],
            input logic signed [QW-1:0] s [3], input logic signed [QW-1:0] p [3],
            input logic signed [QW-1:0] q [3], input logic signed [QW-1:0] rc,
            input logic signed [QW-1:0] tu, input logic signed [QW-1:0] tv,
            input logic signed [QW-1:0] tt, input logic signed [QW-1:0] t);
        logic signed [QW-1:0] r;
        unique case (sel)
            rtc_pkg::SRC_D0:    r = d0;
            rtc_pkg::SRC_D1:    r = d1;
            rtc_pkg::SRC_D2:    r = d2;
            rtc_pkg::SRC_E10:   r = e1[0];
            rtc_pkg::SRC_E11:   r = e1[1];
            rtc_pkg::SRC_E12:   r = e1[2];
            rtc_pkg::SRC_E20:   r = e2[0];
            rtc_pkg::SRC_E21:   r = e2[1];
            rtc_pkg::SRC_E22:   r = e2[2];
            rtc_pkg::SRC_S0:    r = s[0];
            rtc_pkg::SRC_S1:    r = s[1];
            rtc_pkg::SRC_S2:    r = s[2];
            rtc_pkg::SRC_P0:    r = p[0];
            rtc_pkg::SRC_P1:    r = p[1];
            rtc_pkg::SRC_P2:    r = p[2];
            rtc_pkg::SRC_Q0:    r = q[0];
            rtc_pkg::SRC_Q1:    r = q[1];
            rtc_pkg::SRC_Q2:    r = q[2];
            rtc_pkg::SRC_RECIP: r = rc;
            rtc_pkg::SRC_TU:    r = tu;
            rtc_pkg::SRC_TV:    r = tv;
            rtc_pkg::SRC_TT:    r = tt;
            rtc_pkg::SRC_T:     r = t;
            default:            r = '0;
        endcase
        return r;
    endfunction

    // Multiply-accumulate: floor-shifted product added to or taken from the base.
    always_comb
    begin
        op_a = pick(cmd.op.a_sel, QW'(dir_reg[0]), QW'(dir_reg[1]), QW'(dir_reg[2]),
                    e1_reg, e2_reg, s_reg, p_reg, q_reg, recip,
                    tu_reg, tv_reg, tt_reg, t_reg);
        op_b = pick(cmd.op.b_sel, QW'(dir_reg[0]), QW'(dir_reg[1]), QW'(dir_reg[2]),
                    e1_reg, e2_reg, s_reg, p_reg, q_reg, recip,
                    tu_reg, tv_reg, tt_reg, t_reg);
        prod    = op_a * op_b;
        prod_sh = prod >>> rtc_pkg::FRAC_BITS;
        unique case (cmd.op.dest)
            rtc_pkg::DST_BP1: base_org = org_reg[1];
            rtc_pkg::DST_BP2: base_org = org_reg[2];
            default:          base_org = org_reg[0];
        endcase
        if (!cmd.op.first)
            base = acc_reg;
        else if (cmd.op.org)
            base = AW'(base_org);
        else
            base = '0;
        acc_next = cmd.op.neg ? (base - prod_sh[AW-1:0]) : (base + prod_sh[AW-1:0]);
        acc_sat  = rtc_pkg::sat_acc(acc_next);
    end

    // Hit test on the scaled barycentrics and distance.
    always_comb
    begin
        uv_sum = {u_reg[QW-1], u_reg} + {v_reg[QW-1], v_reg};
        max_s  = $signed({1'b0, max_reg});
        status.hit_ok = (u_reg >= rtc_pkg::MINUS1) && (u_reg <= rtc_pkg::ONE_P1)
                     && (v_reg >= rtc_pkg::MINUS1)
                     && (uv_sum <= $signed({rtc_pkg::ONE_P1[QW-1], rtc_pkg::ONE_P1}))
                     && (t_reg > $signed(QW'(1))) && (t_reg <= max_s)
                     && (t_reg < best_dist_reg);
        status.det_zero = (det_reg == '0);
        status.div_busy = div_busy;
    end

    // Ray registers, written through the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= DW'(64'd1 << rtc_pkg::FRAC_BITS);
            max_reg    <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rtc_pkg::CFG_ORIGIN_X: org_reg[0] <= cfg_data;
                rtc_pkg::CFG_ORIGIN_Y: org_reg[1] <= cfg_data;
                rtc_pkg::CFG_ORIGIN_Z: org_reg[2] <= cfg_data;
                rtc_pkg::CFG_DIR_X:    dir_reg[0] <= cfg_data[DW-1:0];
                rtc_pkg::CFG_DIR_Y:    dir_reg[1] <= cfg_data[DW-1:0];
                rtc_pkg::CFG_DIR_Z:    dir_reg[2] <= cfg_data[DW-1:0];
                rtc_pkg::CFG_MAX_DIST: max_reg    <= cfg_data[rtc_pkg::DIST_W-1:0];
                default:               ;
            endcase
        end
    end

    // Edge vectors on transfer, then program results into their registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= rtc_pkg::sat_diff({vert_b[i][QW-1], vert_b[i]}
                                               - {vert_a[i][QW-1], vert_a[i]});
                e2_reg[i] <= rtc_pkg::sat_diff({vert_c[i][QW-1], vert_c[i]}
                                               - {vert_a[i][QW-1], vert_a[i]});
                s_reg[i]  <= rtc_pkg::sat_diff({org_reg[i][QW-1], org_reg[i]}
                                               - {vert_a[i][QW-1], vert_a[i]});
            end
        end
        if (cmd.exec)
        begin
            acc_reg <= acc_next;
            if (cmd.op.last)
            begin
                unique case (cmd.op.dest)
                    rtc_pkg::DST_P0:  p_reg[0] <= acc_sat;
                    rtc_pkg::DST_P1:  p_reg[1] <= acc_sat;
                    rtc_pkg::DST_P2:  p_reg[2] <= acc_sat;
                    rtc_pkg::DST_DET: det_reg  <= acc_sat;
                    rtc_pkg::DST_TU:  tu_reg   <= acc_sat;
                    rtc_pkg::DST_Q0:  q_reg[0] <= acc_sat;
                    rtc_pkg::DST_Q1:  q_reg[1] <= acc_sat;
                    rtc_pkg::DST_Q2:  q_reg[2] <= acc_sat;
                    rtc_pkg::DST_TV:  tv_reg   <= acc_sat;
                    rtc_pkg::DST_TT:  tt_reg   <= acc_sat;
                    rtc_pkg::DST_U:   u_reg    <= acc_sat;
                    rtc_pkg::DST_V:   v_reg    <= acc_sat;
                    rtc_pkg::DST_T:   t_reg    <= acc_sat;
                    default:          ;
                endcase
            end
        end
    end

    // Closest-hit state: cleared at mesh start, updated on an accepted hit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
            best_dist_reg  <= rtc_pkg::Q_MAX;
            best_pt_reg[0] <= '0;
            best_pt_reg[1] <= '0;
            best_pt_reg[2] <= '0;
        end
        else
        begin
            if (cmd.mesh_start)
            begin
                best_found_reg <= 1'b0;
                best_dist_reg  <= $signed({1'b0, max_reg});
                best_pt_reg[0] <= '0;
                best_pt_reg[1] <= '0;
                best_pt_reg[2] <= '0;
            end
            if (cmd.commit)
            begin
                best_found_reg <= 1'b1;
                best_dist_reg  <= t_reg;
            end
            if (cmd.exec && cmd.op.last)
            begin
                unique case (cmd.op.dest)
                    rtc_pkg::DST_BP0: best_pt_reg[0] <= acc_sat;
                    rtc_pkg::DST_BP1: best_pt_reg[1] <= acc_sat;
                    rtc_pkg::DST_BP2: best_pt_reg[2] <= acc_sat;
                    default:          ;
                endcase
            end
        end
    end

    // Result registers, loaded when the mesh result is handed over.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_found_reg <= best_found_reg;
            out_dist_reg  <= best_found_reg ? best_dist_reg[rtc_pkg::DIST_W-1:0] : '0;
            out_pt_reg[0] <= best_pt_reg[0];
            out_pt_reg[1] <= best_pt_reg[1];
            out_pt_reg[2] <= best_pt_reg[2];
        end
    end

    assign hit_found = out_found_reg;
    assign hit_dist  = out_dist_reg;
    assign hit_x     = out_pt_reg[0];
    assign hit_y     = out_pt_reg[1];
    assign hit_z     = out_pt_reg[2];

endmodule

`default_nettype wire

>>> rtl/core/rtc_ctrl.sv
// Controller: sequences the datapath program for each triangle and runs both
// handshakes. Depends on rtc_pkg for the command, status and step encodings.
`timescale 1ns / 1ps
`default_nettype none

module rtc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             last_triangle,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output rtc_pkg::cmd_t         cmd,
    input  wire rtc_pkg::status_t status
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RUN    = 2'd1;
    localparam logic [1:0] S_CHECK  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [rtc_pkg::PC_W-1:0] pc_reg, pc_next;
    logic                     last_reg, last_next;
    logic                     mesh_open_reg, mesh_open_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     accept;
    logic                     hold;
    logic                     abort;
    rtc_pkg::op_t             op;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign op        = rtc_pkg::get_op(pc_reg);
    assign hold      = op.wait_div && status.div_busy;
    assign abort     = (pc_reg == rtc_pkg::PC_DIV_START) && status.det_zero;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        last_next      = last_reg;
        mesh_open_next = mesh_open_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.op         = op;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load       = 1'b1;
                    cmd.mesh_start = !mesh_open_reg;
                    mesh_open_next = 1'b1;
                    last_next      = last_triangle;
                    pc_next        = '0;
                    state_next     = S_RUN;
                end
            end
            S_RUN:
            begin
                if (abort)
                    state_next = S_FINISH;
                else if (!hold)
                begin
                    cmd.exec      = 1'b1;
                    cmd.div_start = (pc_reg == rtc_pkg::PC_DIV_START);
                    pc_next       = pc_reg + 1'b1;
                    if (pc_reg == rtc_pkg::PC_T_DONE)
                        state_next = S_CHECK;
                    else if (pc_reg == rtc_pkg::PC_END)
                        state_next = S_FINISH;
                end
            end
            S_CHECK:
            begin
                if (status.hit_ok)
                begin
                    cmd.commit = 1'b1;
                    pc_next    = rtc_pkg::PC_POINT;
                    state_next = S_RUN;
                end
                else
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!last_reg)
                    state_next = S_IDLE;
                else if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    mesh_open_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            last_reg      <= 1'b0;
            mesh_open_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            last_reg      <= last_next;
            mesh_open_reg <= mesh_open_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ray_triangle_closest_hit_core.sv
// Top level of the closest-hit ray/triangle core: controller plus datapath.
// Depends on rtc_pkg, rtc_ctrl, rtc_datapath and rtc_div.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_stall  | a_x..c_z, last_triangle
//   out     | out_valid / out_stall| hit_found, hit_dist, hit_x, hit_y, hit_z
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// The gap from one triangle transfer to the next is shortest when det is zero,
// longer for any other miss and longest for a new closest hit, set by the
// reciprocal divider that starts after det and by the single shared multiplier.
// Reset returns the ray registers to their defaults and clears the mesh state.
// A waiting result does not block the next triangle; only a following last
// triangle holds until out_stall drops. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module ray_triangle_closest_hit_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        a_x,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        a_y,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        a_z,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        b_x,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        b_y,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        b_z,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        c_x,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        c_y,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        c_z,
    input  wire logic                                  last_triangle,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       hit_found,
    output logic [rtc_pkg::DIST_W-1:0]                 hit_dist,
    output logic signed [rtc_pkg::Q_W-1:0]             hit_x,
    output logic signed [rtc_pkg::Q_W-1:0]             hit_y,
    output logic signed [rtc_pkg::Q_W-1:0]             hit_z,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [rtc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [rtc_pkg::Q_W-1:0]               cfg_data
);

    rtc_pkg::cmd_t    cmd;
    rtc_pkg::status_t status;

    // Configuration writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    rtc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .last_triangle (last_triangle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cmd           (cmd),
        .status        (status)
    );

    rtc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .c_x       (c_x),
        .c_y       (c_y),
        .c_z       (c_z),
        .hit_found (hit_found),
        .hit_dist  (hit_dist),
        .hit_x     (hit_x),
        .hit_y     (hit_y),
        .hit_z     (hit_z)
    );

endmodule

`default_nettype wire

>>> rtl/core/rtc_checker.sv
// Port-level checker for the closest-hit core, bound to the top level.
// Depends on rtc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rtc_checker (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    input  wire logic                                  in_stall,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        a_x,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        a_y,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        a_z,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        b_x,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        b_y,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        b_z,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        c_x,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        c_y,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        c_z,
    input  wire logic                                  last_triangle,
    input  wire logic                                  out_valid,
    input  wire logic                                  out_stall,
    input  wire logic                                  hit_found,
    input  wire logic [rtc_pkg::DIST_W-1:0]            hit_dist,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        hit_x,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        hit_y,
    input  wire logic signed [rtc_pkg::Q_W-1:0]        hit_z,
    input  wire logic                                  cfg_valid,
    input  wire logic                                  cfg_ready,
    input  wire logic [rtc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [rtc_pkg::Q_W-1:0]               cfg_data
);

    // A stalled result stays offered.
    `RTC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // A stalled result keeps its payload.
    `RTC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(hit_dist) && $stable(hit_x) && $stable(hit_y) && $stable(hit_z) && $stable(hit_found))

    // The block is busy right after it takes a triangle.
    `RTC_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)

    // A miss reports zero distance and a zero point.
    `RTC_ASSERT_SAME(a_miss_zero, out_valid && !hit_found, hit_dist == '0 && hit_x == '0 && hit_y == '0 && hit_z == '0)

    // A hit lies beyond the one-LSB tolerance.
    `RTC_ASSERT_SAME(a_hit_range, out_valid && hit_found, hit_dist > rtc_pkg::DIST_W'(1))

endmodule

bind ray_triangle_closest_hit_core rtc_checker u_rtc_checker (.*);

`default_nettype wire

>>> verif/ray_triangle_closest_hit_checker.sv
// Scoreboard for the closest-hit ray/triangle core: watches the config, triangle
// and result channels, predicts each mesh result in fixed point and compares.
// Depends on rtc_pkg for widths and register indexes.
`timescale 1ns / 1ps

module ray_triangle_closest_hit_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic signed [rtc_pkg::Q_W-1:0]     a_x,
    input  logic signed [rtc_pkg::Q_W-1:0]     a_y,
    input  logic signed [rtc_pkg::Q_W-1:0]     a_z,
    input  logic signed [rtc_pkg::Q_W-1:0]     b_x,
    input  logic signed [rtc_pkg::Q_W-1:0]     b_y,
    input  logic signed [rtc_pkg::Q_W-1:0]     b_z,
    input  logic signed [rtc_pkg::Q_W-1:0]     c_x,
    input  logic signed [rtc_pkg::Q_W-1:0]     c_y,
    input  logic signed [rtc_pkg::Q_W-1:0]     c_z,
    input  logic                               last_triangle,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic                               hit_found,
    input  logic [rtc_pkg::DIST_W-1:0]         hit_dist,
    input  logic signed [rtc_pkg::Q_W-1:0]     hit_x,
    input  logic signed [rtc_pkg::Q_W-1:0]     hit_y,
    input  logic signed [rtc_pkg::Q_W-1:0]     hit_z,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [rtc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rtc_pkg::Q_W-1:0]            cfg_data,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 results_seen,
    output int                                 hits_seen
);
    import rtc_pkg::*;

    localparam longint ONE_Q = longint'(1) << FRAC_BITS;

    typedef struct {
        logic                  found;
        logic [DIST_W-1:0]     distance;
        logic signed [Q_W-1:0] pt [3];
    } mesh_result_t;

    // Ray registers as the block should hold them.
    longint ray_org [3];
    longint ray_dir [3];
    longint ray_max;

    // Closest-hit state of the open mesh.
    logic   near_found;
    longint near_dist;
    longint near_pt [3];
    logic   mesh_active;

    mesh_result_t result_q [$];

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // Q product, rounding toward minus infinity.
    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return p >>> FRAC_BITS;
    endfunction

    function automatic longint fx_dot(input longint a [3], input longint b [3]);
        return clamp32(fx_mul(a[0], b[0]) + fx_mul(a[1], b[1]) + fx_mul(a[2], b[2]));
    endfunction

    function automatic void fx_cross(input longint a [3], input longint b [3],
                                     output longint r [3]);
        r[0] = clamp32(fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]));
        r[1] = clamp32(fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]));
        r[2] = clamp32(fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]));
    endfunction

    // Intersect one triangle with the ray and update the closest hit.
    task automatic trace_triangle(input longint va [3], input longint vb [3],
                                  input longint vc [3]);
        longint e1 [3], e2 [3], s [3], p [3], q [3];
        longint det, recip, u, v, t;
        if (!mesh_active)
        begin
            near_found  = 1'b0;
            near_dist   = ray_max;
            near_pt     = '{0, 0, 0};
            mesh_active = 1'b1;
        end
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = clamp32(vb[i] - va[i]);
            e2[i] = clamp32(vc[i] - va[i]);
            s[i]  = clamp32(ray_org[i] - va[i]);
        end
        fx_cross(ray_dir, e2, p);
        det = fx_dot(e1, p);
        if (det == 0)
            return;
        recip = clamp32((longint'(1) << (2 * FRAC_BITS)) / det);
        u = clamp32(fx_mul(fx_dot(s, p), recip));
        if (u < -1 || u > ONE_Q + 1)
            return;
        fx_cross(s, e1, q);
        v = clamp32(fx_mul(fx_dot(ray_dir, q), recip));
        if (v < -1 || u + v > ONE_Q + 1)
            return;
        t = clamp32(fx_mul(recip, fx_dot(e2, q)));
        if (t > 1 && t <= ray_max && t < near_dist)
        begin
            near_found = 1'b1;
            near_dist  = t;
            for (int i = 0; i < 3; i++)
                near_pt[i] = clamp32(ray_org[i] + fx_mul(ray_dir[i], t));
        end
    endtask

    // Compare one result transfer with the oldest expected result.
    task automatic check_result();
        mesh_result_t want;
        logic [31:0] got_f [5];
        logic [31:0] want_f [5];
        string fname [5];
        fname = '{"hit_found", "hit_dist", "hit_x", "hit_y", "hit_z"};
        results_seen++;
        if (hit_found)
            hits_seen++;
        if (result_q.size() == 0)
        begin
            $display("%0t: result with nothing expected (found %0d dist %h)",
                     $time, hit_found, hit_dist);
            fail_count++;
            return;
        end
        want = result_q.pop_front();
        got_f  = '{32'(hit_found), 32'(hit_dist), hit_x, hit_y, hit_z};
        want_f = '{32'(want.found), 32'(want.distance), want.pt[0], want.pt[1], want.pt[2]};
        for (int i = 0; i < 5; i++)
            if (got_f[i] !== want_f[i])
            begin
                $display("%0t: %s mismatch, expected %h, got %h",
                         $time, fname[i], want_f[i], got_f[i]);
                fail_count++;
            end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_org     = '{0, 0, 0};
            ray_dir     = '{0, 0, ONE_Q};
            ray_max     = 64'h7FFF_FFFF;
            near_found  = 1'b0;
            near_dist   = ray_max;
            near_pt     = '{0, 0, 0};
            mesh_active = 1'b0;
            result_q.delete();
            fail_count   = 0;
            results_seen = 0;
            hits_seen    = 0;
        end
        else
        begin
            // Register write transfer.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ORIGIN_X: ray_org[0] = longint'(signed'(cfg_data));
                    CFG_ORIGIN_Y: ray_org[1] = longint'(signed'(cfg_data));
                    CFG_ORIGIN_Z: ray_org[2] = longint'(signed'(cfg_data));
                    CFG_DIR_X:    ray_dir[0] = longint'(signed'(cfg_data[DIR_W-1:0]));
                    CFG_DIR_Y:    ray_dir[1] = longint'(signed'(cfg_data[DIR_W-1:0]));
                    CFG_DIR_Z:    ray_dir[2] = longint'(signed'(cfg_data[DIR_W-1:0]));
                    CFG_MAX_DIST: ray_max    = longint'(cfg_data[DIST_W-1:0]);
                    default: ;
                endcase
            end
            // Triangle transfer.
            if (in_valid && !in_stall)
            begin
                mesh_result_t r;
                trace_triangle('{a_x, a_y, a_z}, '{b_x, b_y, b_z}, '{c_x, c_y, c_z});
                if (last_triangle)
                begin
                    r.found    = near_found;
                    r.distance = near_found ? DIST_W'(near_dist) : '0;
                    for (int i = 0; i < 3; i++)
                        r.pt[i] = Q_W'(near_pt[i]);
                    result_q.push_back(r);
                    mesh_active = 1'b0;
                end
            end
            // Result transfer.
            if (out_valid && !out_stall)
                check_result();
        end
        pending = result_q.size();
    end

endmodule

>>> verif/ray_triangle_closest_hit_core_tb.sv
// Testbench top for the closest-hit ray/triangle core: drives rays and meshes
// with bursty triangles and a stalling receiver, and gives the verdict.
// Depends on rtc_pkg, the core and ray_triangle_closest_hit_checker.
`timescale 1ns / 1ps

module ray_triangle_closest_hit_core_tb;
    import rtc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam longint ONE_Q = longint'(1) << FRAC_BITS;
    localparam int RANDOM_ITEMS = 1430;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [Q_W-1:0] a_x = '0, a_y = '0, a_z = '0;
    logic signed [Q_W-1:0] b_x = '0, b_y = '0, b_z = '0;
    logic signed [Q_W-1:0] c_x = '0, c_y = '0, c_z = '0;
    logic last_triangle = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit_found;
    logic [DIST_W-1:0] hit_dist;
    logic signed [Q_W-1:0] hit_x, hit_y, hit_z;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [Q_W-1:0] cfg_data = '0;

    int fail_count, pending, results_seen, hits_seen;
    int tri_sent = 0;
    int mesh_sent = 0;
    int burst_left = 0;

    // Ray as currently programmed, used to aim triangles at it.
    longint ray_o [3] = '{0, 0, 0};
    longint ray_d [3] = '{0, 0, ONE_Q};

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    ray_triangle_closest_hit_core uut (.*);

    ray_triangle_closest_hit_checker scoreboard (.*);

    // Receiver stall pattern: free, light random, and long holds, changing mode.
    int stall_mode = 0;
    int stall_cnt = 0;
    int mode_cnt = 0;
    always @(negedge clk)
    begin
        if (mode_cnt == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_cnt = $urandom_range(50, 400);
        end
        mode_cnt--;
        case (stall_mode)
            0: out_stall = 1'b0;
            1: out_stall = ($urandom_range(0, 9) < 3);
            default:
            begin
                if (stall_cnt == 0)
                    stall_cnt = $urandom_range(1, 20);
                stall_cnt--;
                if (stall_cnt == 0)
                    out_stall = ~out_stall;
            end
        endcase
    end

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        case (idx)
            CFG_ORIGIN_X: ray_o[0] = longint'(signed'(data));
            CFG_ORIGIN_Y: ray_o[1] = longint'(signed'(data));
            CFG_ORIGIN_Z: ray_o[2] = longint'(signed'(data));
            CFG_DIR_X:    ray_d[0] = longint'(signed'(data[DIR_W-1:0]));
            CFG_DIR_Y:    ray_d[1] = longint'(signed'(data[DIR_W-1:0]));
            CFG_DIR_Z:    ray_d[2] = longint'(signed'(data[DIR_W-1:0]));
            default: ;
        endcase
    endtask

    // Program a whole ray; junk above the used bits must be ignored.
    task automatic load_ray(input longint o [3], input longint d [3], input longint maxd);
        write_reg(CFG_ORIGIN_X, Q_W'(o[0]));
        write_reg(CFG_ORIGIN_Y, Q_W'(o[1]));
        write_reg(CFG_ORIGIN_Z, Q_W'(o[2]));
        write_reg(CFG_DIR_X, {14'($urandom_range(0, 16383)), DIR_W'(d[0])});
        write_reg(CFG_DIR_Y, {14'($urandom_range(0, 16383)), DIR_W'(d[1])});
        write_reg(CFG_DIR_Z, {14'($urandom_range(0, 16383)), DIR_W'(d[2])});
        write_reg(CFG_MAX_DIST, {1'($urandom), DIST_W'(maxd)});
        if ($urandom_range(0, 1))
            write_reg(CFG_UNUSED, $urandom);
    endtask

    // Hold off until every result is back and the core has drained.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (70) @(negedge clk);
    endtask

    // One triangle transfer, with the sender's bursts and gaps.
    task automatic send_tri(input longint v [9], input bit last);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, 30)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        {a_x, a_y, a_z} = {Q_W'(v[0]), Q_W'(v[1]), Q_W'(v[2])};
        {b_x, b_y, b_z} = {Q_W'(v[3]), Q_W'(v[4]), Q_W'(v[5])};
        {c_x, c_y, c_z} = {Q_W'(v[6]), Q_W'(v[7]), Q_W'(v[8])};
        last_triangle = last;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        tri_sent++;
        if (last)
            mesh_sent++;
    endtask

    // Triangle whose centroid sits on the ray at distance t.
    task automatic aim_tri(input longint t, input longint span, output longint v [9]);
        longint p [3], w1 [3], w2 [3];
        for (int i = 0; i < 3; i++)
        begin
            p[i]  = clamp32(ray_o[i] + ((ray_d[i] * t) >>> FRAC_BITS));
            w1[i] = longint'($urandom_range(0, 2 * span)) - span;
            w2[i] = longint'($urandom_range(0, 2 * span)) - span;
            v[i]     = clamp32(p[i] + w1[i]);
            v[3 + i] = clamp32(p[i] + w2[i]);
            v[6 + i] = clamp32(p[i] - w1[i] - w2[i]);
        end
    endtask

    function automatic longint pick_dist();
        case ($urandom_range(0, 9))
            0: return longint'($urandom_range(0, 4));
            1: return -longint'($urandom_range(1, 40)) * ONE_Q;
            2: return longint'($urandom_range(100, 30000)) * ONE_Q;
            default: return longint'($urandom_range(1, 64)) * ONE_Q + $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic longint pick_span();
        case ($urandom_range(0, 3))
            0: return longint'($urandom_range(1, 4000));
            1: return longint'($urandom_range(1, 64)) * ONE_Q;
            default: return longint'($urandom_range(1, 8)) * ONE_Q;
        endcase
    endfunction

    // Random triangle: mostly aimed at the ray, some degenerate, some pure noise.
    task automatic random_tri(output longint v [9]);
        int kind;
        longint pt;
        kind = $urandom_range(0, 19);
        if (kind < 17)
            aim_tri(pick_dist(), pick_span(), v);
        else if (kind == 17)
        begin
            aim_tri(pick_dist(), pick_span(), v);
            for (int i = 0; i < 3; i++)
                v[6 + i] = v[i];
        end
        else
            for (int i = 0; i < 9; i++)
            begin
                pt = longint'(signed'(32'($urandom)));
                v[i] = pt;
            end
    endtask

    longint tri_v [9];
    longint twin [9];
    longint cfg_o [3];
    longint cfg_d [3];
    longint cfg_max;
    int mesh_len;

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset ray (origin 0, +z). Far hit, nearer hit, tie, then last.
        aim_tri(10 * ONE_Q, ONE_Q, tri_v);
        send_tri(tri_v, 1'b0);
        aim_tri(3 * ONE_Q, 2 * ONE_Q, tri_v);
        twin = tri_v;
        send_tri(tri_v, 1'b0);
        send_tri(twin, 1'b0);
        aim_tri(-5 * ONE_Q, ONE_Q, tri_v);
        send_tri(tri_v, 1'b1);
        // Degenerate triangle and a plane parallel to the ray.
        send_tri('{ONE_Q, 0, 5 * ONE_Q, ONE_Q, 0, 5 * ONE_Q, ONE_Q, 0, 5 * ONE_Q}, 1'b1);
        send_tri('{ONE_Q, 0, 0, ONE_Q, ONE_Q, 0, ONE_Q, 0, ONE_Q}, 1'b1);
        // Triangles aimed at one and two LSB along the ray, and a triangle missed to the side.
        aim_tri(1, ONE_Q, tri_v);
        send_tri(tri_v, 1'b1);
        aim_tri(2, ONE_Q, tri_v);
        send_tri(tri_v, 1'b1);
        send_tri('{5 * ONE_Q, 5 * ONE_Q, ONE_Q, 6 * ONE_Q, 5 * ONE_Q, ONE_Q,
                   5 * ONE_Q, 6 * ONE_Q, ONE_Q}, 1'b1);
        // Field extremes.
        send_tri('{9{64'sd2147483647}}, 1'b0);
        send_tri('{9{-64'sd2147483648}}, 1'b0);
        send_tri('{64'sd2147483647, -64'sd2147483648, 0, -64'sd2147483648,
                   64'sd2147483647, -1, 1, 0, 64'sd2147483647}, 1'b1);
        // A register write in the middle of a mesh.
        aim_tri(20 * ONE_Q, ONE_Q, tri_v);
        send_tri(tri_v, 1'b0);
        wait_idle();
        write_reg(CFG_MAX_DIST, 32'(15 * ONE_Q));
        aim_tri(12 * ONE_Q, ONE_Q, tri_v);
        send_tri(tri_v, 1'b1);
        // Extreme origin with a ray heading out of range.
        wait_idle();
        load_ray('{64'sd2147483647, -64'sd2147483648, 64'sd2147483647},
                 '{ONE_Q, -ONE_Q, 0}, 64'h7FFF_FFFF);
        aim_tri(200 * ONE_Q, ONE_Q, tri_v);
        send_tri(tri_v, 1'b1);
        send_tri('{0, 0, 64'sd2147483647, ONE_Q, 0, 0, 0, ONE_Q, 0}, 1'b1);

        // Random phases, each with a new ray.
        for (int ph = 0; ph < 10; ph++)
        begin
            wait_idle();
            for (int i = 0; i < 3; i++)
            begin
                cfg_o[i] = ($urandom_range(0, 3) == 0) ? longint'(signed'(32'($urandom)))
                                                        : longint'($urandom_range(0, 200)) * ONE_Q
                                                          - 100 * ONE_Q;
                cfg_d[i] = 0;
            end
            if (ph == 3)
                cfg_d = '{46341, 46341, 0};
            else if (ph == 6)
                cfg_d = '{37837, -37837, 37837};
            else
                cfg_d[$urandom_range(0, 2)] = $urandom_range(0, 1) ? ONE_Q : -ONE_Q;
            case (ph % 4)
                0: cfg_max = 64'h7FFF_FFFF;
                1: cfg_max = longint'($urandom_range(1, 40)) * ONE_Q;
                2: cfg_max = (ph == 2) ? 0 : 64'h7FFF_FFFF;
                default: cfg_max = $urandom_range(0, 32'h7FFF_FFFF);
            endcase
            load_ray(cfg_o, cfg_d, cfg_max);
            for (int n = 0; n < RANDOM_ITEMS / 10; )
            begin
                mesh_len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
                for (int k = 0; k < mesh_len; k++)
                begin
                    random_tri(tri_v);
                    send_tri(tri_v, k == mesh_len - 1);
                    n++;
                    // Occasionally repeat a triangle to exercise the tie rule.
                    if (k < mesh_len - 1 && $urandom_range(0, 9) == 0)
                    begin
                        send_tri(tri_v, 1'b0);
                        n++;
                    end
                end
            end
        end

        wait_idle();
        repeat (100) @(negedge clk);
        $display("Run covered %0d triangles in %0d meshes; %0d results checked, %0d with a hit.",
                 tri_sent, mesh_sent, results_seen, hits_seen);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results still expected.", pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
